>>> src/inverted_index_tf_scorer_assert.svh
// assertion macros for the inverted index scorer checker
`ifndef INVERTED_INDEX_TF_SCORER_ASSERT_SVH
`define INVERTED_INDEX_TF_SCORER_ASSERT_SVH

// same-cycle implication, disabled in reset
`define ITTF_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ittf assertion failed");

// next-cycle implication, disabled in reset
`define ITTF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ittf assertion failed");

// same-cycle implication, also checked in reset
`define ITTF_ASSERT_ALWAYS(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |-> (cons)) \
    else $error("ittf assertion failed");

`endif

>>> src/ittf_pkg.sv
// shared constants and types of the inverted index scorer
package ittf_pkg;

  localparam int NDOCS     = 4096;
  localparam int NWORDS    = 4096;
  localparam int NPOSTINGS = 65536;

  localparam int DOC_AW  = $clog2(NDOCS);
  localparam int WORD_AW = $clog2(NWORDS);
  localparam int POST_AW = $clog2(NPOSTINGS);

  localparam int TF_W    = 16;
  localparam int CNT_W   = 13;
  localparam int DOCF_W  = 12;
  localparam int LEN_W   = 16;
  localparam int SCORE_W = 16;

  localparam logic [CNT_W-1:0] NDOCS_C  = CNT_W'(NDOCS);
  localparam logic [CNT_W-1:0] HIT_MAX  = '1;

  typedef enum logic [2:0] {
    CMD_LOAD_HDR  = 3'd0,
    CMD_LOAD_POST = 3'd1,
    CMD_CLEAR     = 3'd2,
    CMD_QUERY     = 3'd3,
    CMD_FETCH     = 3'd4
  } cmd_t;

  typedef enum logic {
    REG_QUERY_TF  = 1'b0,
    REG_DOC_COUNT = 1'b1
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HDR,
    ST_PREQ,
    ST_PWAIT,
    ST_SWAIT,
    ST_FCHK,
    ST_FWAIT,
    ST_DONE
  } state_t;

endpackage

>>> src/inverted_index_tf_scorer.sv
// Inverted index scorer: header, posting and score memories with a command sequencer.
// Clear sweeps the score ram; a query walks the word's posting list and scores each
//   document in range, skipping the rest; a fetch scans documents until a hit or the end.
// Throughput: one command at a time; s_tready returns once the result is loaded.
// Reset starts a sweep of the score ram; s_tready stays low until it ends.
module inverted_index_tf_scorer (
  input  logic        clk,
  input  logic        rst,
  // input beat
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [2:0]  s_tuser,   // cmd
  input  logic [71:0] s_tdata,   // word_index, address, list_length, doc_index, term_freq
  // result beat
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [0:0]  m_tuser,   // found
  output logic [47:0] m_tdata,   // doc_number, score, candidate_count, zero pad
  // configuration
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int HDR_W  = ittf_pkg::POST_AW + ittf_pkg::LEN_W;
  localparam int POST_W = ittf_pkg::DOCF_W + ittf_pkg::TF_W;
  localparam int SC_W   = ittf_pkg::SCORE_W + 1;

  ittf_pkg::state_t state, state_next;

  // input fields
  logic [11:0] in_word;
  logic [15:0] in_addr, in_len, in_tf;
  logic [11:0] in_doc;
  logic        accept;

  assign in_word  = s_tdata[11:0];
  assign in_addr  = s_tdata[27:12];
  assign in_len   = s_tdata[43:28];
  assign in_doc   = s_tdata[55:44];
  assign in_tf    = s_tdata[71:56];
  assign s_tready = (state == ittf_pkg::ST_IDLE);
  assign accept   = s_tvalid && s_tready;

  // registers
  logic [15:0] query_tf;
  logic [12:0] doc_count, limit;
  logic [11:0] clr_addr;
  logic        clr_cmd;
  logic [15:0] post_addr, remain;
  logic [11:0] cur_doc;
  logic [15:0] cur_tf;
  logic [12:0] cursor, hit_total;
  logic        res_found;
  logic [12:0] res_num;
  logic [15:0] res_score;
  logic        out_free;

  assign limit    = (doc_count > ittf_pkg::NDOCS_C) ? ittf_pkg::NDOCS_C : doc_count;
  assign out_free = !m_tvalid || m_tready;

  // memory ports
  logic                             hdr_we, post_we, sc_we;
  logic [ittf_pkg::WORD_AW-1:0]     hdr_waddr, hdr_raddr;
  logic [HDR_W-1:0]                 hdr_wdata, hdr_rdata;
  logic [ittf_pkg::POST_AW-1:0]     post_waddr, post_raddr;
  logic [POST_W-1:0]                post_wdata, post_rdata;
  logic [ittf_pkg::DOC_AW-1:0]      sc_waddr, sc_raddr;
  logic [SC_W-1:0]                  sc_wdata, sc_rdata;

  ittf_ram #(.WIDTH(HDR_W), .DEPTH(ittf_pkg::NWORDS)) u_hdr_ram (
    .clk(clk), .we(hdr_we), .waddr(hdr_waddr), .wdata(hdr_wdata),
    .raddr(hdr_raddr), .rdata(hdr_rdata)
  );

  ittf_ram #(.WIDTH(POST_W), .DEPTH(ittf_pkg::NPOSTINGS)) u_post_ram (
    .clk(clk), .we(post_we), .waddr(post_waddr), .wdata(post_wdata),
    .raddr(post_raddr), .rdata(post_rdata)
  );

  ittf_ram #(.WIDTH(SC_W), .DEPTH(ittf_pkg::NDOCS)) u_score_ram (
    .clk(clk), .we(sc_we), .waddr(sc_waddr), .wdata(sc_wdata),
    .raddr(sc_raddr), .rdata(sc_rdata)
  );

  // fields read back from the rams
  logic [11:0] rd_doc;
  logic [15:0] rd_tf, rd_score, add, min_tf;
  logic        rd_hit;
  logic [16:0] sum;

  assign rd_doc   = post_rdata[11:0];
  assign rd_tf    = post_rdata[27:12];
  assign rd_score = sc_rdata[15:0];
  assign rd_hit   = sc_rdata[16];
  assign min_tf   = (query_tf < cur_tf) ? query_tf : cur_tf;
  assign add      = min_tf;
  assign sum      = {1'b0, rd_score} + {1'b0, add};

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ittf_pkg::ST_CLEAR: begin
        if (clr_addr == '1) begin
          state_next = clr_cmd ? ittf_pkg::ST_DONE : ittf_pkg::ST_IDLE;
        end
      end
      ittf_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (s_tuser)
            ittf_pkg::CMD_CLEAR: state_next = ittf_pkg::ST_CLEAR;
            ittf_pkg::CMD_QUERY: state_next = ittf_pkg::ST_HDR;
            ittf_pkg::CMD_FETCH: state_next = ittf_pkg::ST_FCHK;
            default:             state_next = ittf_pkg::ST_DONE;
          endcase
        end
      end
      ittf_pkg::ST_HDR:  state_next = ittf_pkg::ST_PREQ;
      ittf_pkg::ST_PREQ: begin
        state_next = (remain == '0) ? ittf_pkg::ST_DONE : ittf_pkg::ST_PWAIT;
      end
      ittf_pkg::ST_PWAIT: begin
        state_next = ({1'b0, rd_doc} < limit) ? ittf_pkg::ST_SWAIT : ittf_pkg::ST_PREQ;
      end
      ittf_pkg::ST_SWAIT: state_next = ittf_pkg::ST_PREQ;
      ittf_pkg::ST_FCHK: begin
        state_next = (cursor >= limit) ? ittf_pkg::ST_DONE : ittf_pkg::ST_FWAIT;
      end
      ittf_pkg::ST_FWAIT: begin
        state_next = rd_hit ? ittf_pkg::ST_DONE : ittf_pkg::ST_FCHK;
      end
      ittf_pkg::ST_DONE: begin
        if (out_free) begin
          state_next = ittf_pkg::ST_IDLE;
        end
      end
      default: state_next = ittf_pkg::ST_IDLE;
    endcase
  end

  // memory control
  always_comb begin
    hdr_we     = 1'b0;
    hdr_waddr  = in_word[ittf_pkg::WORD_AW-1:0];
    hdr_wdata  = {in_len, in_addr};
    hdr_raddr  = in_word[ittf_pkg::WORD_AW-1:0];
    post_we    = 1'b0;
    post_waddr = in_addr[ittf_pkg::POST_AW-1:0];
    post_wdata = {in_tf, in_doc};
    post_raddr = post_addr[ittf_pkg::POST_AW-1:0];
    sc_we      = 1'b0;
    sc_waddr   = clr_addr;
    sc_wdata   = '0;
    sc_raddr   = rd_doc;
    unique case (state)
      ittf_pkg::ST_CLEAR: sc_we = 1'b1;
      ittf_pkg::ST_IDLE: begin
        hdr_we  = accept && (s_tuser == ittf_pkg::CMD_LOAD_HDR);
        post_we = accept && (s_tuser == ittf_pkg::CMD_LOAD_POST);
      end
      ittf_pkg::ST_SWAIT: begin
        sc_we    = 1'b1;
        sc_waddr = cur_doc;
        sc_wdata = {1'b1, sum[16] ? 16'hFFFF : sum[15:0]};
      end
      ittf_pkg::ST_FCHK: sc_raddr = cursor[ittf_pkg::DOC_AW-1:0];
      default: ;
    endcase
  end

  // sequencer datapath and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ittf_pkg::ST_CLEAR;
      clr_addr  <= '0;
      clr_cmd   <= 1'b0;
      cursor    <= '0;
      hit_total <= '0;
      query_tf  <= '0;
      doc_count <= ittf_pkg::NDOCS_C;
      m_tvalid  <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        unique case (cfg_index)
          ittf_pkg::REG_QUERY_TF:  query_tf  <= cfg_data;
          ittf_pkg::REG_DOC_COUNT: doc_count <= cfg_data[12:0];
          default: ;
        endcase
      end
      // output register: load a result, drop the beat once taken
      if ((state == ittf_pkg::ST_DONE) && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ittf_pkg::ST_CLEAR: clr_addr <= clr_addr + 12'd1;
        ittf_pkg::ST_IDLE: begin
          if (accept) begin
            res_found <= 1'b0;
            res_num   <= '0;
            res_score <= '0;
            clr_cmd   <= 1'b1;
            clr_addr  <= '0;
            if (s_tuser == ittf_pkg::CMD_CLEAR) begin
              hit_total <= '0;
              cursor    <= '0;
            end
          end
        end
        ittf_pkg::ST_HDR: begin
          post_addr <= hdr_rdata[15:0];
          remain    <= hdr_rdata[31:16];
        end
        ittf_pkg::ST_PREQ: begin
          if (remain != '0) begin
            post_addr <= post_addr + 16'd1;
            remain    <= remain - 16'd1;
          end
        end
        ittf_pkg::ST_PWAIT: begin
          cur_doc <= rd_doc;
          cur_tf  <= rd_tf;
        end
        ittf_pkg::ST_SWAIT: begin
          if (!rd_hit && hit_total != ittf_pkg::HIT_MAX) begin
            hit_total <= hit_total + 13'd1;
          end
        end
        ittf_pkg::ST_FCHK: begin
          if (cursor >= limit) begin
            cursor <= limit;
          end
        end
        ittf_pkg::ST_FWAIT: begin
          cursor <= cursor + 13'd1;
          if (rd_hit) begin
            res_found <= 1'b1;
            res_num   <= cursor + 13'd1;
            res_score <= rd_score;
          end
        end
        ittf_pkg::ST_DONE: begin
          if (out_free) begin
            m_tuser  <= res_found;
            m_tdata  <= {6'd0, hit_total, res_score, res_num};
          end
        end
        default: ;
      endcase
    end
  end

endmodule

>>> src/ittf_ram.sv
// generic single-port-write ram with registered read
module ittf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> src/ittf_checker.sv
// port-level checker for the inverted index scorer, bound to the top level
`include "inverted_index_tf_scorer_assert.svh"

module ittf_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [0:0]  m_tuser,
  input logic [47:0] m_tdata
);

  `ITTF_ASSERT_NOW(a_found_has_doc, m_tvalid && m_tuser[0], m_tdata[12:0] != 13'd0)
  `ITTF_ASSERT_NOW(a_miss_is_zero, m_tvalid && !m_tuser[0], m_tdata[28:0] == 29'd0)
  `ITTF_ASSERT_NOW(a_doc_in_range, m_tvalid, m_tdata[12:0] <= 13'd4096)
  `ITTF_ASSERT_ALWAYS(a_sweep_after_rst, $past(rst), !s_tready)
  `ITTF_ASSERT_NEXT(a_beat_held, m_tvalid && !m_tready, m_tvalid)

endmodule

bind inverted_index_tf_scorer ittf_checker u_ittf_checker (
  .clk(clk), .rst(rst), .s_tready(s_tready), .m_tvalid(m_tvalid),
  .m_tready(m_tready), .m_tuser(m_tuser), .m_tdata(m_tdata)
);
